// ===== rtl/mccd_pkg.sv =====
// Shared types and constants for the multi-client credit tick divider.
// Depends on nothing; the top level, the credit unit and the testbench refer to it by scoped names.

package mccd_pkg;

	// Stored rate and credit width; the user must keep CLOCK_RATE at or below 255, the block does not enforce it.
	localparam int unsigned RateW = 8;
	localparam int unsigned DueW  = 16;

	typedef enum logic [1:0] {
		OP_TICK        = 2'd0,
		OP_SUBSCRIBE   = 2'd1,
		OP_UNSUBSCRIBE = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Result of one pass through the shared credit unit.
	typedef struct packed {
		logic             due;
		logic [RateW-1:0] credit;
	} credit_res_t;

endpackage

// ===== rtl/multi_client_credit_tick_divider.sv =====
// Top level of the multi-client credit tick divider: sequencer, slot table and result register.
// Depends on mccd_pkg, mccd_ram and mccd_credit_unit.

// The block keeps a table of NUM_CLIENTS client slots, each with a valid mark, a rate and a
// credit, and answers every input beat with exactly one result beat. A subscribe beat (opcode 1)
// clamps the requested rate to 1..CLOCK_RATE and stores it; a free slot also starts with zero
// credit, while a slot already in use keeps its credit. An unsubscribe beat (opcode 2) frees the
// slot. Client ids at or above NUM_CLIENTS and opcode 3 change nothing. A tick beat (opcode 0)
// counts only while the block is running, that is, while animations_allowed is set and at least
// one slot is valid: the frame counter then increments and every valid slot adds its rate to its
// credit, and a slot whose credit reaches CLOCK_RATE drops CLOCK_RATE and raises its bit in
// due_mask. Only slots below sixteen can show a due bit. A result carries the due mask of that
// beat (zero unless it was an applied tick), the frame count and the running flag after it.
// An applied tick walks the table in ST_WALK, passes ST_DRAIN and ST_DONE and is loaded into
// the result register; the block takes no new beat until it is back in ST_IDLE. The period of
// ticks is set by the single credit adder, which visits one slot per cycle through the read
// port of the rate and credit memories. Every other beat goes from its acceptance through
// ST_DONE to the result register. The result register parts the two sides, and a result that
// is not taken holds the block in its final state until the sink accepts.
// The rate and credit memories are never cleared; a slot's contents are used only once a
// subscribe has written them. The valid marks are flip-flops that reset clears at once.

module multi_client_credit_tick_divider #(
	parameter int unsigned NUM_CLIENTS = 16,
	parameter int unsigned CLOCK_RATE  = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: animations_allowed.
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	// Input beats.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [3:0] client_id, [13:4] rate_request, [15:14] zero
	input  logic [1:0]  s_tuser,  // [1:0] opcode
	// Result beats.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // [15:0] due_mask, [47:16] frame, [48] running, [55:49] zero
);

	localparam int unsigned IdxW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_CLIENTS - 1);
	localparam logic [9:0] RateMax = 10'(CLOCK_RATE);

	// Input fields.
	logic [1:0]  opcode;
	logic [3:0]  client_id;
	logic [9:0]  rate_request;

	assign opcode       = s_tuser;
	assign client_id    = s_tdata[3:0];
	assign rate_request = s_tdata[13:4];

	// Control and slot state.
	mccd_pkg::state_t               state_q, state_d;
	logic                           allowed_q;
	logic [NUM_CLIENTS-1:0]         valid_q;
	logic [31:0]                    frame_q;
	logic [IdxW-1:0]                idx_q;
	logic                           proc_vld_s1;
	logic [IdxW-1:0]                proc_idx_s1;
	logic [mccd_pkg::DueW-1:0]      due_q;
	logic                           m_tvalid_q;
	logic [55:0]                    m_tdata_q;

	// Decoded item and sequencer controls.
	logic                           accept;
	logic                           load_out;
	logic                           running_now;
	logic                           tick_applies;
	logic                           id_in_range;
	logic [IdxW-1:0]                slot_id;
	logic                           is_sub;
	logic                           is_unsub;
	logic [mccd_pkg::RateW-1:0]     rate_clamped;
	logic                           idx_last;

	// Memory and credit unit wiring.
	logic                           wb;
	logic                           credit_we;
	logic [IdxW-1:0]                credit_waddr;
	logic [mccd_pkg::RateW-1:0]     credit_wdata;
	logic [mccd_pkg::RateW-1:0]     rate_rd;
	logic [mccd_pkg::RateW-1:0]     credit_rd;
	mccd_pkg::credit_res_t          unit_res;

	assign running_now  = allowed_q & (|valid_q);
	assign id_in_range  = (32'(client_id) < NUM_CLIENTS);
	assign slot_id      = IdxW'(client_id);
	assign idx_last     = (idx_q == LastIdx);
	assign tick_applies = (opcode == mccd_pkg::OP_TICK) && running_now;
	assign is_sub       = accept && (opcode == mccd_pkg::OP_SUBSCRIBE) && id_in_range;
	assign is_unsub     = accept && (opcode == mccd_pkg::OP_UNSUBSCRIBE) && id_in_range;

	// Requests of zero become one, and anything above CLOCK_RATE saturates.
	always_comb begin
		if (rate_request == 10'd0) begin
			rate_clamped = mccd_pkg::RateW'(1);
		end else if (rate_request > RateMax) begin
			rate_clamped = mccd_pkg::RateW'(CLOCK_RATE);
		end else begin
			rate_clamped = rate_request[mccd_pkg::RateW-1:0];
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mccd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: an applied tick walks the table one slot per cycle, then drains the
	// last read; every other item goes straight to the result stage.
	always_comb begin
		state_d  = state_q;
		accept   = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			mccd_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					accept  = 1'b1;
					state_d = tick_applies ? mccd_pkg::ST_WALK : mccd_pkg::ST_DONE;
				end
			end
			mccd_pkg::ST_WALK: begin
				if (idx_last) begin
					state_d = mccd_pkg::ST_DRAIN;
				end
			end
			mccd_pkg::ST_DRAIN: begin
				state_d = mccd_pkg::ST_DONE;
			end
			mccd_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = mccd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mccd_pkg::ST_IDLE;
			end
		endcase
	end

	assign s_tready = (state_q == mccd_pkg::ST_IDLE);

	// The slot whose memory data arrived this cycle is written back only if it is in use.
	assign wb = proc_vld_s1 && valid_q[proc_idx_s1];

	// The credit store is written by the walk, or by a subscribe to a free slot.
	always_comb begin
		if (wb) begin
			credit_we    = 1'b1;
			credit_waddr = proc_idx_s1;
			credit_wdata = unit_res.credit;
		end else begin
			credit_we    = is_sub && !valid_q[slot_id];
			credit_waddr = slot_id;
			credit_wdata = '0;
		end
	end

	mccd_ram #(
		.Width (mccd_pkg::RateW),
		.Depth (NUM_CLIENTS)
	) u_rate_ram (
		.clk   (clk),
		.we    (is_sub),
		.waddr (slot_id),
		.wdata (rate_clamped),
		.raddr (idx_q),
		.rdata (rate_rd)
	);

	mccd_ram #(
		.Width (mccd_pkg::RateW),
		.Depth (NUM_CLIENTS)
	) u_credit_ram (
		.clk   (clk),
		.we    (credit_we),
		.waddr (credit_waddr),
		.wdata (credit_wdata),
		.raddr (idx_q),
		.rdata (credit_rd)
	);

	mccd_credit_unit #(
		.CLOCK_RATE (CLOCK_RATE)
	) u_credit_unit (
		.credit (credit_rd),
		.rate   (rate_rd),
		.res    (unit_res)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allowed_q   <= 1'b1;
			valid_q     <= '0;
			frame_q     <= '0;
			idx_q       <= '0;
			proc_vld_s1 <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				allowed_q <= cfg_wdata;
			end
			if (is_sub) begin
				valid_q[slot_id] <= 1'b1;
			end else if (is_unsub) begin
				valid_q[slot_id] <= 1'b0;
			end
			if (accept && tick_applies) begin
				frame_q <= frame_q + 32'd1;
			end
			if (accept) begin
				idx_q <= '0;
			end else if ((state_q == mccd_pkg::ST_WALK) && !idx_last) begin
				idx_q <= idx_q + IdxW'(1);
			end
			proc_vld_s1 <= (state_q == mccd_pkg::ST_WALK);
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers. A due bit for a slot at sixteen or above shifts out of the mask.
	always_ff @(posedge clk) begin
		proc_idx_s1 <= idx_q;
		if (accept) begin
			due_q <= '0;
		end else if (wb && unit_res.due) begin
			due_q <= due_q | (mccd_pkg::DueW'(1) << proc_idx_s1);
		end
		if (load_out) begin
			m_tdata_q <= {7'd0, running_now, frame_q, due_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== rtl/mccd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the slot rate and credit stores.

module mccd_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                        wdata,
	input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                        rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/mccd_credit_unit.sv =====
// Shared credit accumulator: adds a slot's rate to its credit and wraps at CLOCK_RATE.
// Depends on mccd_pkg for the stored width and the result struct.

module mccd_credit_unit #(
	parameter int unsigned CLOCK_RATE = 60
) (
	input  logic [mccd_pkg::RateW-1:0] credit,
	input  logic [mccd_pkg::RateW-1:0] rate,
	output mccd_pkg::credit_res_t      res
);

	localparam logic [mccd_pkg::RateW:0] Limit = (mccd_pkg::RateW + 1)'(CLOCK_RATE);

	logic [mccd_pkg::RateW:0] sum;
	logic [mccd_pkg::RateW:0] wrapped;

	always_comb begin
		sum        = {1'b0, credit} + {1'b0, rate};
		wrapped    = sum - Limit;
		res.due    = (sum >= Limit);
		res.credit = res.due ? wrapped[mccd_pkg::RateW-1:0] : sum[mccd_pkg::RateW-1:0];
	end

endmodule

// ===== rtl/mccd_checker.sv =====
// Port-level checker for the multi-client credit tick divider, with its bind statement.
// Depends only on the top level's ports.

module mccd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic        cfg_wdata,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// A stalled result beat holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// The block works on one beat at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted again right after an accept");

	// A slot can only be due on an applied tick; the result must then show running.
	a_due_needs_running: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] == 16'd0) || m_tdata[48])
		else $error("due bits reported while not running");

	// Padding bits of the result stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[55:49] == 7'd0))
		else $error("result padding bits not zero");

endmodule

bind multi_client_credit_tick_divider mccd_checker u_mccd_checker (.*);

// ===== test/multi_client_credit_tick_divider_tb.sv =====
// Self-checking testbench for multi_client_credit_tick_divider: directed and random
// subscribe, unsubscribe and tick beats, checked against a slot-table predictor.
// Depends on mccd_pkg and the block's RTL.

module multi_client_credit_tick_divider_tb;

	localparam int unsigned NUM_CLIENTS = 16;
	localparam int unsigned CLOCK_RATE  = 60;
	// Opcode 3 has no member in the package; the block must treat it as a no-op.
	localparam logic [1:0]  OP_UNUSED   = 2'd3;
	localparam int unsigned IDLE_LIMIT  = 2000;
	localparam int unsigned HOLD_AT     = 400;
	localparam int unsigned HOLD_LEN    = 300;

	typedef struct {
		logic [1:0] op;
		logic [3:0] id;
		logic [9:0] rate;
		bit         drain_first;
	} divider_req_t;

	typedef struct packed {
		logic [15:0] due;
		logic [31:0] frame;
		logic        running;
	} divider_res_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [55:0] m_tdata;

	// Predictor state: a private copy of the slot table and the enable register.
	logic                   allow_model;
	logic [NUM_CLIENTS-1:0] slot_live;
	logic [7:0]             rate_tbl   [NUM_CLIENTS];
	logic [7:0]             credit_tbl [NUM_CLIENTS];
	logic [31:0]            frame_model;

	divider_req_t pending_reqs[$];
	divider_res_t awaited_results[$];
	divider_req_t cur_req;

	bit          calm;
	bit          hold_done;
	int unsigned tx_gap;
	int unsigned rx_gap;
	int unsigned hold_left;
	int unsigned beats_in;
	int unsigned beats_out;
	int unsigned ticks_counted;
	int unsigned due_flags;
	int unsigned mismatches;

	multi_client_credit_tick_divider #(
		.NUM_CLIENTS(NUM_CLIENTS),
		.CLOCK_RATE (CLOCK_RATE)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Applies one accepted beat to the slot table and returns the result it must produce.
	function automatic divider_res_t step_slot_model(divider_req_t r);
		divider_res_t res;
		logic [7:0]   rate;
		logic [8:0]   sum;
		int           i;
		res.due = '0;
		if (r.rate == 10'd0)
			rate = 8'd1;
		else if (r.rate > CLOCK_RATE)
			rate = CLOCK_RATE[7:0];
		else
			rate = r.rate[7:0];
		case (r.op)
			mccd_pkg::OP_TICK: begin
				if (allow_model && slot_live != '0) begin
					frame_model++;
					ticks_counted++;
					for (i = 0; i < NUM_CLIENTS; i++) begin
						if (slot_live[i]) begin
							sum = {1'b0, credit_tbl[i]} + {1'b0, rate_tbl[i]};
							if (sum >= CLOCK_RATE) begin
								sum = sum - 9'(CLOCK_RATE);
								if (i < 16)
									res.due[i] = 1'b1;
							end
							credit_tbl[i] = sum[7:0];
						end
					end
				end
			end
			mccd_pkg::OP_SUBSCRIBE: begin
				// An existing subscriber only changes rate; a new one starts from zero credit.
				rate_tbl[r.id] = rate;
				if (!slot_live[r.id]) begin
					slot_live[r.id]  = 1'b1;
					credit_tbl[r.id] = 8'd0;
				end
			end
			mccd_pkg::OP_UNSUBSCRIBE: begin
				slot_live[r.id] = 1'b0;
			end
			default: begin
			end
		endcase
		due_flags += $countones(res.due);
		res.frame   = frame_model;
		res.running = allow_model && (slot_live != '0);
		return res;
	endfunction

	// Mostly back-to-back, sometimes a short gap, now and then a long pause; always back-to-back while calm is set.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 45);
	endfunction

	function automatic logic [9:0] pick_rate();
		case ($urandom_range(0, 9))
			0: return 10'd0;
			1: return 10'd1;
			2: return 10'(CLOCK_RATE - 1);
			3: return 10'(CLOCK_RATE);
			4: return 10'(CLOCK_RATE + 1);
			5: return 10'd1023;
			6, 7: return 10'($urandom_range(1, CLOCK_RATE));
			default: return 10'($urandom_range(0, 1023));
		endcase
	endfunction

	task automatic push_req(logic [1:0] op, logic [3:0] id, logic [9:0] rate, bit drain_first);
		divider_req_t r;
		r.op          = op;
		r.id          = id;
		r.rate        = rate;
		r.drain_first = drain_first;
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	// Random traffic: ticks dominate, with subscribes, unsubscribes, the unused opcode
	// and the occasional sweep that frees every slot so the block stops running.
	task automatic random_phase(int unsigned n);
		int unsigned k;
		int unsigned pick;
		int unsigned j;
		bit          first;
		k = 0;
		while (k < n) begin
			pick  = $urandom_range(0, 199);
			first = (k == 0) || ($urandom_range(0, 99) == 0);
			if (pick < 110) begin
				push_req(mccd_pkg::OP_TICK, 4'($urandom_range(0, 15)),
					10'($urandom_range(0, 1023)), first);
				k++;
			end else if (pick < 160) begin
				push_req(mccd_pkg::OP_SUBSCRIBE, 4'($urandom_range(0, 15)), pick_rate(), first);
				k++;
			end else if (pick < 185) begin
				push_req(mccd_pkg::OP_UNSUBSCRIBE, 4'($urandom_range(0, 15)),
					10'($urandom_range(0, 1023)), first);
				k++;
			end else if (pick < 198) begin
				push_req(OP_UNUSED, 4'($urandom_range(0, 15)),
					10'($urandom_range(0, 1023)), first);
				k++;
			end else begin
				for (j = 0; j < NUM_CLIENTS; j++)
					push_req(mccd_pkg::OP_UNSUBSCRIBE, 4'(j), 10'd0, first && j == 0);
				k += NUM_CLIENTS;
			end
		end
	endtask

	task automatic drain_all();
		while (pending_reqs.size() != 0 || s_tvalid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// The register is only touched while nothing is in flight.
	task automatic set_animations(logic v);
		@(posedge clk);
		cfg_we      <= 1'b1;
		cfg_wdata   <= v;
		allow_model  = v;
		@(posedge clk);
		cfg_we      <= 1'b0;
	endtask

	// Sender: offers the oldest pending beat and holds it until the block takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			tx_gap   <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				awaited_results.insert(awaited_results.size(), step_slot_model(cur_req));
				beats_in++;
			end
			if (s_tvalid && !s_tready) begin
				// Still waiting for the block; keep the beat steady.
			end else if (tx_gap > 0) begin
				tx_gap   <= tx_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() != 0 &&
					!(pending_reqs[0].drain_first && awaited_results.size() != 0)) begin
				cur_req   = pending_reqs.pop_front();
				s_tdata  <= {2'b00, cur_req.rate, cur_req.id};
				s_tuser  <= cur_req.op;
				s_tvalid <= 1'b1;
				tx_gap   <= pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: checks each result beat and paces m_tready, including one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		divider_res_t want;
		divider_res_t got;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			rx_gap    <= 0;
			hold_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				beats_out++;
				got.due     = m_tdata[15:0];
				got.frame   = m_tdata[47:16];
				got.running = m_tdata[48];
				if (awaited_results.size() == 0) begin
					if (mismatches < 10)
						$display("result beat with nothing awaited: due %h frame %0d running %b",
							got.due, got.frame, got.running);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display({"result %0d mismatch: due %h/%h frame %0d/%0d ",
								"running %b/%b (expected/actual)"}, beats_out,
								want.due, got.due, want.frame, got.frame,
								want.running, got.running);
						mismatches++;
					end
				end
			end
			if (beats_out == HOLD_AT && !hold_done) begin
				// Starve the output so the result register fills and the input backs up.
				hold_done  = 1'b1;
				hold_left <= HOLD_LEN;
				m_tready  <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap   <= rx_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				rx_gap   <= pick_gap();
			end
		end
	end

	// Watchdog: ends the run if no beat moves on either side for too long.
	initial begin : watchdog
		int unsigned idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		allow_model = 1'b1;
		slot_live   = '0;
		frame_model = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: idle ticks, free-slot unsubscribe, clamping, rate update, bit patterns.
		set_animations(1'b1);
		push_req(mccd_pkg::OP_TICK,        4'd0,  10'd0,    1'b0);
		push_req(mccd_pkg::OP_UNSUBSCRIBE, 4'd5,  10'd0,    1'b0);
		push_req(OP_UNUSED,                4'd0,  10'd0,    1'b0);
		push_req(mccd_pkg::OP_SUBSCRIBE,   4'd0,  10'd0,    1'b0);
		push_req(mccd_pkg::OP_SUBSCRIBE,   4'd15, 10'd1023, 1'b0);
		push_req(mccd_pkg::OP_SUBSCRIBE,   4'd7,  10'd60,   1'b0);
		push_req(mccd_pkg::OP_SUBSCRIBE,   4'd8,  10'd61,   1'b0);
		push_req(mccd_pkg::OP_SUBSCRIBE,   4'd3,  10'd59,   1'b0);
		push_req(mccd_pkg::OP_TICK,        4'd0,  10'd0,    1'b0);
		push_req(mccd_pkg::OP_TICK,        4'd0,  10'd0,    1'b0);
		push_req(mccd_pkg::OP_TICK,        4'd15, 10'd1023, 1'b0);
		push_req(mccd_pkg::OP_SUBSCRIBE,   4'd3,  10'd30,   1'b0);
		push_req(mccd_pkg::OP_TICK,        4'd0,  10'd0,    1'b0);
		push_req(mccd_pkg::OP_TICK,        4'd0,  10'd0,    1'b0);
		push_req(mccd_pkg::OP_UNSUBSCRIBE, 4'd15, 10'd1023, 1'b0);
		push_req(mccd_pkg::OP_TICK,        4'd0,  10'd0,    1'b0);
		push_req(OP_UNUSED,                4'd15, 10'd1023, 1'b0);
		push_req(mccd_pkg::OP_SUBSCRIBE,   4'd10, 10'd512,  1'b0);
		push_req(mccd_pkg::OP_SUBSCRIBE,   4'd5,  10'd341,  1'b0);
		push_req(mccd_pkg::OP_SUBSCRIBE,   4'd10, 10'd682,  1'b0);
		push_req(mccd_pkg::OP_TICK,        4'd0,  10'd0,    1'b0);
		push_req(mccd_pkg::OP_TICK,        4'd0,  10'd0,    1'b1);
		drain_all();

		// With animations off every tick must be ignored; run this phase without gaps.
		set_animations(1'b0);
		calm = 1'b1;
		random_phase(40);
		drain_all();
		calm = 1'b0;

		set_animations(1'b1);
		random_phase(420);
		drain_all();

		set_animations(1'b0);
		random_phase(60);
		drain_all();

		set_animations(1'b1);
		random_phase(410);
		drain_all();

		repeat (30) @(posedge clk);
		$display("Sent %0d beats, checked %0d results; %0d ticks counted, %0d due flags.",
			beats_in, beats_out, ticks_counted, due_flags);
		$display("Animations toggled through five phases, with one %0d-cycle output stall.",
			HOLD_LEN);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, awaited_results.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mccd_pkg.sv
rtl/mccd_ram.sv
rtl/mccd_credit_unit.sv
rtl/multi_client_credit_tick_divider.sv
rtl/mccd_checker.sv
test/multi_client_credit_tick_divider_tb.sv
